// File: hw/rtl/ult_pkg.sv
// Package: types, codes and the control store of the unordered list table.
package ult_pkg;

  localparam int unsigned RowsDef = 4;
  localparam int unsigned ColsDef = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned FillW   = 5;
  localparam int unsigned StepW   = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_MODIFY = 2'd2,
    OP_SORT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // branch conditions
  typedef enum logic [2:0] {
    C_FULL  = 3'd0,  // count at capacity
    C_EMPTY = 3'd1,  // count zero
    C_IEND  = 3'd2,  // i >= count
    C_MATCH = 3'd3,  // read word equals key
    C_SHEND = 3'd4,  // i + 1 >= count
    C_J0    = 3'd5,  // j zero
    C_GE    = 3'd6,  // held value not below read word (signed)
    C_MOD   = 3'd7   // operation is modify
  } cond_e;

  typedef enum logic [2:0] {
    JMP_NEXT     = 3'd0,
    JMP_COND     = 3'd1,
    JMP_GOTO     = 3'd2,
    JMP_DISPATCH = 3'd3,
    JMP_FIN      = 3'd4
  } jmp_e;

  typedef enum logic [1:0] {
    RA_I  = 2'd0,
    RA_I1 = 2'd1,
    RA_J1 = 2'd2
  } raddr_e;

  typedef enum logic [1:0] {
    WA_CNT = 2'd0,
    WA_I   = 2'd1,
    WA_J   = 2'd2
  } waddr_e;

  typedef enum logic [1:0] {
    WD_KEY = 2'd0,
    WD_NV  = 2'd1,
    WD_RD  = 2'd2,
    WD_V   = 2'd3
  } wdata_e;

  typedef enum logic [1:0] {
    I_KEEP = 2'd0,
    I_ZERO = 2'd1,
    I_ONE  = 2'd2,
    I_INC  = 2'd3
  } iop_e;

  typedef enum logic [1:0] {
    JJ_KEEP   = 2'd0,
    JJ_FROM_I = 2'd1,
    JJ_DEC    = 2'd2
  } jop_e;

  typedef enum logic [1:0] {
    CNT_KEEP = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cntop_e;

  typedef enum logic [1:0] {
    PO_KEEP = 2'd0,
    PO_ZERO = 2'd1,
    PO_CNT  = 2'd2,
    PO_I    = 2'd3
  } posop_e;

  typedef logic [StepW-1:0] step_t;

  // program labels
  localparam step_t S_IDLE   = 5'd0;
  localparam step_t S_INS    = 5'd1;
  localparam step_t S_INS_W  = 5'd2;
  localparam step_t S_FULLX  = 5'd3;
  localparam step_t S_SRCH   = 5'd4;
  localparam step_t S_RD     = 5'd5;
  localparam step_t S_CMP    = 5'd6;
  localparam step_t S_INC    = 5'd7;
  localparam step_t S_HIT    = 5'd8;
  localparam step_t S_SHRD   = 5'd9;
  localparam step_t S_SHWR   = 5'd10;
  localparam step_t S_DEC    = 5'd11;
  localparam step_t S_MOD    = 5'd12;
  localparam step_t S_EMPTYX = 5'd13;
  localparam step_t S_NFX    = 5'd14;
  localparam step_t S_SORT   = 5'd15;
  localparam step_t S_SOUT   = 5'd16;
  localparam step_t S_SV     = 5'd17;
  localparam step_t S_SIN    = 5'd18;
  localparam step_t S_SCMP   = 5'd19;
  localparam step_t S_SMOV   = 5'd20;
  localparam step_t S_SPUT   = 5'd21;
  localparam step_t S_FIN    = 5'd22;

  typedef struct packed {
    jmp_e    jmp;
    cond_e   cond;
    step_t   tgt;
    logic    rd_en;
    raddr_e  raddr;
    logic    wr_en;
    waddr_e  waddr;
    wdata_e  wdata;
    iop_e    i_op;
    jop_e    j_op;
    logic    v_ld;
    cntop_e  cnt_op;
    logic    st_we;
    status_e status;
    posop_e  pos_op;
  } ctrl_t;

  localparam ctrl_t CtrlNop = '{
    jmp: JMP_NEXT, cond: C_FULL, tgt: S_IDLE, rd_en: 1'b0, raddr: RA_I,
    wr_en: 1'b0, waddr: WA_I, wdata: WD_KEY, i_op: I_KEEP, j_op: JJ_KEEP,
    v_ld: 1'b0, cnt_op: CNT_KEEP, st_we: 1'b0, status: ST_OK, pos_op: PO_KEEP
  };

  // control store
  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t c;
    c = CtrlNop;
    unique case (pc)
      S_IDLE:   c.jmp = JMP_DISPATCH;
      // insert
      S_INS:    begin c.jmp = JMP_COND; c.cond = C_FULL; c.tgt = S_FULLX; end
      S_INS_W:  begin
        c.jmp = JMP_GOTO; c.tgt = S_FIN;
        c.wr_en = 1'b1; c.waddr = WA_CNT; c.wdata = WD_KEY;
        c.cnt_op = CNT_INC; c.st_we = 1'b1; c.status = ST_OK; c.pos_op = PO_CNT;
      end
      S_FULLX:  begin
        c.jmp = JMP_GOTO; c.tgt = S_FIN;
        c.st_we = 1'b1; c.status = ST_FULL; c.pos_op = PO_ZERO;
      end
      // delete / modify: linear search
      S_SRCH:   begin
        c.jmp = JMP_COND; c.cond = C_EMPTY; c.tgt = S_EMPTYX; c.i_op = I_ZERO;
      end
      S_RD:     begin
        c.jmp = JMP_COND; c.cond = C_IEND; c.tgt = S_NFX;
        c.rd_en = 1'b1; c.raddr = RA_I;
      end
      S_CMP:    begin c.jmp = JMP_COND; c.cond = C_MATCH; c.tgt = S_HIT; end
      S_INC:    begin c.jmp = JMP_GOTO; c.tgt = S_RD; c.i_op = I_INC; end
      S_HIT:    begin
        c.jmp = JMP_COND; c.cond = C_MOD; c.tgt = S_MOD;
        c.st_we = 1'b1; c.status = ST_OK; c.pos_op = PO_I;
      end
      // delete: close the gap
      S_SHRD:   begin
        c.jmp = JMP_COND; c.cond = C_SHEND; c.tgt = S_DEC;
        c.rd_en = 1'b1; c.raddr = RA_I1;
      end
      S_SHWR:   begin
        c.jmp = JMP_GOTO; c.tgt = S_SHRD;
        c.wr_en = 1'b1; c.waddr = WA_I; c.wdata = WD_RD; c.i_op = I_INC;
      end
      S_DEC:    begin c.jmp = JMP_GOTO; c.tgt = S_FIN; c.cnt_op = CNT_DEC; end
      S_MOD:    begin
        c.jmp = JMP_GOTO; c.tgt = S_FIN;
        c.wr_en = 1'b1; c.waddr = WA_I; c.wdata = WD_NV;
      end
      S_EMPTYX: begin
        c.jmp = JMP_GOTO; c.tgt = S_FIN;
        c.st_we = 1'b1; c.status = ST_EMPTY; c.pos_op = PO_ZERO;
      end
      S_NFX:    begin
        c.jmp = JMP_GOTO; c.tgt = S_FIN;
        c.st_we = 1'b1; c.status = ST_NOT_FOUND; c.pos_op = PO_ZERO;
      end
      // sort: insertion sort over the filled entries
      S_SORT:   begin
        c.i_op = I_ONE; c.st_we = 1'b1; c.status = ST_OK; c.pos_op = PO_ZERO;
      end
      S_SOUT:   begin
        c.jmp = JMP_COND; c.cond = C_IEND; c.tgt = S_FIN;
        c.rd_en = 1'b1; c.raddr = RA_I; c.j_op = JJ_FROM_I;
      end
      S_SV:     c.v_ld = 1'b1;
      S_SIN:    begin
        c.jmp = JMP_COND; c.cond = C_J0; c.tgt = S_SPUT;
        c.rd_en = 1'b1; c.raddr = RA_J1;
      end
      S_SCMP:   begin c.jmp = JMP_COND; c.cond = C_GE; c.tgt = S_SPUT; end
      S_SMOV:   begin
        c.jmp = JMP_GOTO; c.tgt = S_SIN;
        c.wr_en = 1'b1; c.waddr = WA_J; c.wdata = WD_RD; c.j_op = JJ_DEC;
      end
      S_SPUT:   begin
        c.jmp = JMP_GOTO; c.tgt = S_SOUT;
        c.wr_en = 1'b1; c.waddr = WA_J; c.wdata = WD_V; c.i_op = I_INC;
      end
      S_FIN:    c.jmp = JMP_FIN;
      default:  begin c.jmp = JMP_GOTO; c.tgt = S_IDLE; end
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/unordered_list_table_unit.sv
// Top level: microcoded unordered list table with insert, delete, modify and sort.
// The unit keeps up to ROWS*COLS signed 32-bit entries in an unordered list in a
// single-port-style memory (one read, one write per cycle, registered read) plus
// a fill count. Each input word carries an opcode in tuser (insert, delete,
// modify, sort) and key / new value in tdata; each one yields exactly one output
// word with a status in tuser and position / fill count in tdata. A short
// program in a control ROM steps a small datapath (index i, index j, held value,
// read register, count). One operation is in flight at a time; a finished
// result sits in an output register, so the next word is taken while it waits.
// Insert needs no search; delete and modify scan the list from the head until the
// key matches or the fill count is reached, and a delete then shifts the later
// entries down by one; sort is an insertion sort whose number of element moves
// is quadratic in the fill count in the worst case. The memory has a single
// registered read port, so every compare or move waits for its read data.
// Entries are not cleared at reset; only data read from entries below the fill count is used.
module unordered_list_table_unit
  import ult_pkg::*;
#(
  parameter int unsigned ROWS = RowsDef,
  parameter int unsigned COLS = ColsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] key, [63:32] new_value
  input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [3:0] position, [8:4] fill_count, rest zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  localparam int unsigned Cap = ROWS * COLS;
  localparam int unsigned CW  = $clog2(Cap + 1);
  localparam int unsigned AW  = (Cap > 1) ? $clog2(Cap) : 1;

  // sequencer
  step_t pc_q, pc_d;
  ctrl_t cw;

  // datapath
  logic [CW-1:0]    cnt_q, i_q, j_q;
  logic [CW:0]      i_inc;
  logic [CW-1:0]    j_dec;
  logic [DataW-1:0] key_q, nv_q, v_q, rd_q, wdata;
  op_e              op_q;
  status_e          status_q;
  logic [PosW-1:0]  pos_q;
  logic [AW-1:0]    raddr, waddr;
  logic             cond_val, in_fire, slot_free;

  // result register
  logic             out_valid_q;
  status_e          out_status_q;
  logic [PosW-1:0]  out_pos_q;
  logic [FillW-1:0] out_fill_q;

  // list storage, no reset
  logic [DataW-1:0] mem_q [Cap];

  assign cw        = ucode(pc_q);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (pc_q == S_IDLE);

  assign i_inc = {1'b0, i_q} + 1'b1;
  assign j_dec = j_q - 1'b1;

  always_comb begin
    case (cw.cond)
      C_FULL:  cond_val = (cnt_q >= CW'(Cap));
      C_EMPTY: cond_val = (cnt_q == '0);
      C_IEND:  cond_val = (i_q >= cnt_q);
      C_MATCH: cond_val = (rd_q == key_q);
      C_SHEND: cond_val = (i_inc >= {1'b0, cnt_q});
      C_J0:    cond_val = (j_q == '0);
      C_GE:    cond_val = !($signed(v_q) < $signed(rd_q));
      C_MOD:   cond_val = (op_q == OP_MODIFY);
      default: cond_val = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    pc_d = pc_q + 1'b1;
    unique case (cw.jmp)
      JMP_NEXT: pc_d = pc_q + 1'b1;
      JMP_COND: if (cond_val) begin
        pc_d = cw.tgt;
      end
      JMP_GOTO: pc_d = cw.tgt;
      JMP_DISPATCH: begin
        if (!in_fire) begin
          pc_d = pc_q;
        end else begin
          case (op_e'(s_axis_tuser))
            OP_INSERT: pc_d = S_INS;
            OP_SORT:   pc_d = S_SORT;
            default:   pc_d = S_SRCH;  // delete and modify share the search
          endcase
        end
      end
      JMP_FIN: pc_d = slot_free ? S_IDLE : pc_q;
      default: pc_d = S_IDLE;
    endcase
  end

  always_comb begin
    case (cw.raddr)
      RA_I1:   raddr = i_inc[AW-1:0];
      RA_J1:   raddr = j_dec[AW-1:0];
      default: raddr = i_q[AW-1:0];
    endcase
    case (cw.waddr)
      WA_CNT:  waddr = cnt_q[AW-1:0];
      WA_J:    waddr = j_q[AW-1:0];
      default: waddr = i_q[AW-1:0];
    endcase
    case (cw.wdata)
      WD_NV:   wdata = nv_q;
      WD_RD:   wdata = rd_q;
      WD_V:    wdata = v_q;
      default: wdata = key_q;
    endcase
  end

  // memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cw.wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (cw.rd_en) begin
      rd_q <= mem_q[raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_e'(s_axis_tuser);
      key_q <= s_axis_tdata[31:0];
      nv_q  <= s_axis_tdata[63:32];
    end
    if (cw.v_ld) begin
      v_q <= rd_q;
    end
    case (cw.i_op)
      I_ZERO:  i_q <= '0;
      I_ONE:   i_q <= CW'(1);
      I_INC:   i_q <= i_inc[CW-1:0];
      default: i_q <= i_q;
    endcase
    case (cw.j_op)
      JJ_FROM_I: j_q <= i_q;
      JJ_DEC:    j_q <= j_dec;
      default:   j_q <= j_q;
    endcase
    if (cw.st_we) begin
      status_q <= cw.status;
    end
    case (cw.pos_op)
      PO_ZERO: pos_q <= '0;
      PO_CNT:  pos_q <= PosW'(cnt_q);
      PO_I:    pos_q <= PosW'(i_q);
      default: pos_q <= pos_q;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      case (cw.cnt_op)
        CNT_INC: cnt_q <= cnt_q + 1'b1;
        CNT_DEC: cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
      if (cw.jmp == JMP_FIN && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded as the program finishes
  always_ff @(posedge clk_i) begin
    if (cw.jmp == JMP_FIN && slot_free) begin
      out_status_q <= status_q;
      out_pos_q    <= pos_q;
      out_fill_q   <= FillW'(cnt_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'd0, out_fill_q, out_pos_q};

endmodule
